/* rtl/bmqd_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// Bounded multi-queue dispatcher package
// Shared widths, limits, register map and the per-server record types.
// -----------------------------------------------------------------------------
package bmqd_pkg;

	localparam int MAX_SERVERS = 32;
	localparam int MAX_QUEUE   = 16;
	localparam int SRV_W       = $clog2(MAX_SERVERS);
	localparam int SRV_CNT_W   = SRV_W + 1;
	localparam int PTR_W       = $clog2(MAX_QUEUE);
	localparam int OCC_W       = PTR_W + 1;
	localparam int SLOT_DEPTH  = MAX_SERVERS * MAX_QUEUE;
	localparam int SLOT_AW     = SRV_W + PTR_W;
	localparam int SVC_W       = 10;
	localparam int TIME_W      = 16;
	localparam int WC_W        = 6;
	localparam int QD_W        = 5;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [TIME_W-1:0] CLOSE_RESET = TIME_W'(540);

	localparam logic [1:0] REG_WINDOW_COUNT = 2'd0;
	localparam logic [1:0] REG_QUEUE_DEPTH  = 2'd1;
	localparam logic [1:0] REG_CLOSE_TIME   = 2'd2;

	typedef struct packed {
		logic [SVC_W-1:0]  head;
		logic [OCC_W-1:0]  occ;
		logic [PTR_W-1:0]  hp;
		logic [TIME_W-1:0] fin;
	} srv_rec_t;

	typedef struct packed {
		logic             en;
		logic [SRV_W-1:0] idx;
		srv_rec_t         rec;
	} srv_wr_t;

	typedef struct packed {
		logic [WC_W-1:0]   window_count;
		logic [QD_W-1:0]   queue_depth;
		logic [TIME_W-1:0] close_time;
	} cfg_t;

endpackage
`default_nettype wire

/* rtl/bmqd_ram.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module bmqd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/bmqd_srv_regs.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// Server state register file
// Head remaining time, occupancy, head pointer and finish time per server,
// with one read index and one record write per cycle.
// -----------------------------------------------------------------------------
module bmqd_srv_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [bmqd_pkg::SRV_W-1:0]  rd_idx,
	output bmqd_pkg::srv_rec_t               rd_rec,
	input  wire bmqd_pkg::srv_wr_t           wr
);

	bmqd_pkg::srv_rec_t regs_q [bmqd_pkg::MAX_SERVERS];

	assign rd_rec = regs_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bmqd_pkg::MAX_SERVERS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (wr.en) begin
			regs_q[wr.idx] <= wr.rec;
		end
	end

endmodule
`default_nettype wire

/* rtl/bmqd_ctrl.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// Dispatch sequencer
// Scans the servers one per cycle through a shared compare and subtract unit,
// picks the target queue, updates the queue storage and reports the result.
// -----------------------------------------------------------------------------
module bmqd_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bmqd_pkg::cfg_t                cfg,
	input  wire logic                          start,
	input  wire logic [bmqd_pkg::SVC_W-1:0]    service_time,
	output logic                               busy,
	output logic [bmqd_pkg::SRV_W-1:0]         rd_idx,
	input  wire bmqd_pkg::srv_rec_t            rec,
	output bmqd_pkg::srv_wr_t                  wr,
	output logic                               ram_we,
	output logic [bmqd_pkg::SLOT_AW-1:0]       ram_waddr,
	output logic [bmqd_pkg::SVC_W-1:0]         ram_wdata,
	output logic [bmqd_pkg::SLOT_AW-1:0]       ram_raddr,
	input  wire logic [bmqd_pkg::SVC_W-1:0]    ram_rdata,
	output logic                               done,
	output logic [bmqd_pkg::SRV_W-1:0]         server_index,
	output logic [bmqd_pkg::TIME_W-1:0]        start_time,
	output logic [bmqd_pkg::TIME_W-1:0]        finish_time,
	output logic                               served
);

	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_SCAN_OCC  = 8'b0000_0010,
		ST_DECIDE    = 8'b0000_0100,
		ST_SCAN_HEAD = 8'b0000_1000,
		ST_SUB       = 8'b0001_0000,
		ST_POP       = 8'b0010_0000,
		ST_LOAD      = 8'b0100_0000,
		ST_FINISH    = 8'b1000_0000
	} state_t;

	state_t                            state_q, state_d;
	logic [bmqd_pkg::SRV_W-1:0]        cnt_q, cnt_d;
	logic [bmqd_pkg::SRV_W-1:0]        best_q, best_d;
	logic [bmqd_pkg::SVC_W-1:0]        min_q, min_d;
	logic [bmqd_pkg::SVC_W-1:0]        svc_q;
	logic [bmqd_pkg::SRV_CNT_W-1:0]    nsrv_q, nsrv_in;
	logic [bmqd_pkg::OCC_W-1:0]        depth_q, depth_in;
	logic                              occ_one_q;
	logic                              last;
	logic [bmqd_pkg::SVC_W-1:0]        cmp_a;
	logic                              cmp_lt;
	logic [bmqd_pkg::SVC_W-1:0]        sub_res;
	logic [bmqd_pkg::PTR_W-1:0]        tail_ptr;
	logic [bmqd_pkg::PTR_W-1:0]        hp_next;
	logic [bmqd_pkg::TIME_W:0]         fin_sum;
	logic [bmqd_pkg::TIME_W-1:0]       fin_sat;

	always_comb begin
		if (cfg.window_count == '0) begin
			nsrv_in = bmqd_pkg::SRV_CNT_W'(1);
		end else if (cfg.window_count > bmqd_pkg::WC_W'(bmqd_pkg::MAX_SERVERS)) begin
			nsrv_in = bmqd_pkg::SRV_CNT_W'(bmqd_pkg::MAX_SERVERS);
		end else begin
			nsrv_in = bmqd_pkg::SRV_CNT_W'(cfg.window_count);
		end
		if (cfg.queue_depth == '0) begin
			depth_in = bmqd_pkg::OCC_W'(1);
		end else if (cfg.queue_depth > bmqd_pkg::QD_W'(bmqd_pkg::MAX_QUEUE)) begin
			depth_in = bmqd_pkg::OCC_W'(bmqd_pkg::MAX_QUEUE);
		end else begin
			depth_in = bmqd_pkg::OCC_W'(cfg.queue_depth);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign last = ({1'b0, cnt_q} == nsrv_q - bmqd_pkg::SRV_CNT_W'(1));
	assign rd_idx = (state_q == ST_SCAN_OCC || state_q == ST_SCAN_HEAD || state_q == ST_SUB)
		? cnt_q : best_q;

	// Shared compare and subtract unit.
	assign cmp_a   = (state_q == ST_SCAN_OCC) ? bmqd_pkg::SVC_W'(rec.occ) : rec.head;
	assign cmp_lt  = cmp_a < min_q;
	assign sub_res = (rec.head != '0) ? rec.head - min_q : '0;

	assign tail_ptr = bmqd_pkg::PTR_W'({1'b0, rec.hp} + bmqd_pkg::OCC_W'(rec.occ));
	assign hp_next  = rec.hp + bmqd_pkg::PTR_W'(1);
	assign fin_sum  = {1'b0, rec.fin} + (bmqd_pkg::TIME_W + 1)'(svc_q);
	assign fin_sat  = fin_sum[bmqd_pkg::TIME_W] ? '1 : fin_sum[bmqd_pkg::TIME_W-1:0];

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		best_d    = best_q;
		min_d     = min_q;
		wr.en     = 1'b0;
		wr.idx    = rd_idx;
		wr.rec    = rec;
		ram_we    = 1'b0;
		ram_waddr = {best_q, tail_ptr};
		ram_wdata = svc_q;
		ram_raddr = {best_q, hp_next};
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cnt_d   = '0;
					state_d = ST_SCAN_OCC;
				end
			end
			ST_SCAN_OCC, ST_SCAN_HEAD: begin
				if (cnt_q == '0 || cmp_lt) begin
					best_d = cnt_q;
					min_d  = cmp_a;
				end
				cnt_d = cnt_q + bmqd_pkg::SRV_W'(1);
				if (last) begin
					cnt_d   = '0;
					state_d = (state_q == ST_SCAN_OCC) ? ST_DECIDE : ST_SUB;
				end
			end
			ST_DECIDE: begin
				if (rec.occ < depth_q) begin
					wr.en      = 1'b1;
					wr.rec.occ = rec.occ + bmqd_pkg::OCC_W'(1);
					if (rec.occ == '0) begin
						wr.rec.head = svc_q;
					end
					ram_we  = 1'b1;
					state_d = ST_FINISH;
				end else begin
					cnt_d   = '0;
					state_d = ST_SCAN_HEAD;
				end
			end
			ST_SUB: begin
				wr.en       = 1'b1;
				wr.rec.head = sub_res;
				cnt_d       = cnt_q + bmqd_pkg::SRV_W'(1);
				if (last) begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				wr.en     = 1'b1;
				wr.rec.hp = hp_next;
				ram_we    = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				wr.en       = 1'b1;
				wr.rec.head = occ_one_q ? svc_q : ram_rdata;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				wr.en      = 1'b1;
				wr.rec.fin = fin_sat;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == ST_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		cnt_q  <= cnt_d;
		best_q <= best_d;
		min_q  <= min_d;
		if (state_q == ST_IDLE && start) begin
			svc_q   <= service_time;
			nsrv_q  <= nsrv_in;
			depth_q <= depth_in;
		end
		if (state_q == ST_POP) begin
			occ_one_q <= (rec.occ == bmqd_pkg::OCC_W'(1));
		end
		if (state_q == ST_FINISH) begin
			server_index <= best_q;
			start_time   <= rec.fin;
			finish_time  <= fin_sat;
			served       <= (rec.fin < cfg.close_time);
		end
	end

endmodule
`default_nettype wire

/* rtl/bounded_multi_queue_dispatcher.sv */
`default_nettype none
// A job scans occupancy over the clamped window count, one server per cycle; with
// room in a queue it then decides and finishes, else it also scans the heads,
// subtracts, pops and loads; busy stays high until the result is issued.
// The receiver cannot stall; done marks each result for exactly one cycle.
// Reset clears all server state and loads the register defaults; slot storage
// holds no reset value and its read data is used only where a job was written.
// -----------------------------------------------------------------------------
// Bounded multi-queue dispatcher
// Join-shortest-queue dispatch over bounded per-server queues with an APB
// configuration port.
// -----------------------------------------------------------------------------
module bounded_multi_queue_dispatcher (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [bmqd_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [bmqd_pkg::DATA_W-1:0]     pwdata,
	output logic      [bmqd_pkg::DATA_W-1:0]     prdata,
	output logic                                 pready,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [bmqd_pkg::SVC_W-1:0]      service_time,
	output logic                                 done,
	output logic      [bmqd_pkg::SRV_W-1:0]      server_index,
	output logic      [bmqd_pkg::TIME_W-1:0]     start_time,
	output logic      [bmqd_pkg::TIME_W-1:0]     finish_time,
	output logic                                 served
);

	bmqd_pkg::cfg_t                    cfg_q;
	logic                              wr_xfer;
	logic [bmqd_pkg::SRV_W-1:0]        rd_idx;
	bmqd_pkg::srv_rec_t                rec;
	bmqd_pkg::srv_wr_t                 wr;
	logic                              ram_we;
	logic [bmqd_pkg::SLOT_AW-1:0]      ram_waddr;
	logic [bmqd_pkg::SVC_W-1:0]        ram_wdata;
	logic [bmqd_pkg::SLOT_AW-1:0]      ram_raddr;
	logic [bmqd_pkg::SVC_W-1:0]        ram_rdata;

	assign pready  = 1'b1;
	assign wr_xfer = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_count <= bmqd_pkg::WC_W'(1);
			cfg_q.queue_depth  <= bmqd_pkg::QD_W'(1);
			cfg_q.close_time   <= bmqd_pkg::CLOSE_RESET;
		end else if (wr_xfer) begin
			case (paddr[3:2])
				bmqd_pkg::REG_WINDOW_COUNT: begin
					cfg_q.window_count <= pwdata[bmqd_pkg::WC_W-1:0];
				end
				bmqd_pkg::REG_QUEUE_DEPTH: begin
					cfg_q.queue_depth <= pwdata[bmqd_pkg::QD_W-1:0];
				end
				bmqd_pkg::REG_CLOSE_TIME: begin
					cfg_q.close_time <= pwdata[bmqd_pkg::TIME_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			bmqd_pkg::REG_WINDOW_COUNT: prdata = bmqd_pkg::DATA_W'(cfg_q.window_count);
			bmqd_pkg::REG_QUEUE_DEPTH:  prdata = bmqd_pkg::DATA_W'(cfg_q.queue_depth);
			bmqd_pkg::REG_CLOSE_TIME:   prdata = bmqd_pkg::DATA_W'(cfg_q.close_time);
			default:                    prdata = '0;
		endcase
	end

	bmqd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.start        (start),
		.service_time (service_time),
		.busy         (busy),
		.rd_idx       (rd_idx),
		.rec          (rec),
		.wr           (wr),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.done         (done),
		.server_index (server_index),
		.start_time   (start_time),
		.finish_time  (finish_time),
		.served       (served)
	);

	bmqd_srv_regs u_srv_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (rd_idx),
		.rd_rec (rec),
		.wr     (wr)
	);

	bmqd_ram #(
		.WIDTH (bmqd_pkg::SVC_W),
		.DEPTH (bmqd_pkg::SLOT_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Bounded multi-queue dispatcher testbench
// Sends jobs through the start/busy command port and reprograms the window
// count, queue depth and close time over APB between phases. Every returned
// result is checked against pinned values or a behavioral model of the queues in
// this file. A short table of directed steps comes first, then random phases.
// -----------------------------------------------------------------------------
module tb;
	import bmqd_pkg::*;

	typedef struct packed {
		logic [SRV_W-1:0]  server;
		logic [TIME_W-1:0] begin_at;
		logic [TIME_W-1:0] end_at;
		logic              in_hours;
	} dispatch_t;

	typedef struct {
		bit               is_reg;
		logic [1:0]       reg_sel;
		logic [31:0]      value;
		logic [SVC_W-1:0] svc;
		bit               pinned;
		dispatch_t        want;
	} plan_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              start;
	logic              busy;
	logic [SVC_W-1:0]  service_time;
	logic              done;
	logic [SRV_W-1:0]  server_index;
	logic [TIME_W-1:0] start_time;
	logic [TIME_W-1:0] finish_time;
	logic              served;

	bounded_multi_queue_dispatcher uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .service_time(service_time),
		.done(done), .server_index(server_index), .start_time(start_time),
		.finish_time(finish_time), .served(served)
	);

	always #5 clk = ~clk;

	// Model of the dispatcher state.
	logic [WC_W-1:0]   m_windows;
	logic [QD_W-1:0]   m_depth;
	logic [TIME_W-1:0] m_close;
	logic [SVC_W-1:0]  m_slot [MAX_SERVERS][MAX_QUEUE];
	logic [SVC_W-1:0]  m_head [MAX_SERVERS];
	logic [OCC_W-1:0]  m_occ [MAX_SERVERS];
	logic [PTR_W-1:0]  m_hp [MAX_SERVERS];
	logic [TIME_W-1:0] m_fin [MAX_SERVERS];

	dispatch_t pending [$];
	plan_row_t plan [$];
	dispatch_t pin_want;
	bit        pin_valid = 1'b0;
	dispatch_t got, want;
	int        errors = 0;
	int        jobs = 0;
	int        checked = 0;
	int        unserved = 0;
	int        saturated = 0;
	int        settings = 0;

	task automatic report(input string what);
		errors++;
		$display("ERROR at %0t: %s", $time, what);
	endtask

	function automatic void expect_result(input dispatch_t r);
		pending.insert(pending.size(), r);
	endfunction

	function automatic void add_step(input plan_row_t r);
		plan.insert(plan.size(), r);
	endfunction

	function automatic dispatch_t dispatch_job(input logic [SVC_W-1:0] svc);
		int        n, depth, best, least, fin;
		dispatch_t r;
		n = (m_windows == 0) ? 1 : (m_windows > MAX_SERVERS) ? MAX_SERVERS : m_windows;
		depth = (m_depth == 0) ? 1 : (m_depth > MAX_QUEUE) ? MAX_QUEUE : m_depth;
		best = 0;
		for (int i = 1; i < n; i++)
			if (m_occ[i] < m_occ[best]) best = i;
		if (m_occ[best] < depth) begin
			if (m_occ[best] == 0) m_head[best] = svc;
			m_slot[best][PTR_W'(m_hp[best] + m_occ[best])] = svc;
			m_occ[best]++;
		end else begin
			best = 0;
			for (int i = 1; i < n; i++)
				if (m_head[i] < m_head[best]) best = i;
			least = m_head[best];
			for (int i = 0; i < n; i++)
				if (m_head[i] != 0) m_head[i] = m_head[i] - SVC_W'(least);
			m_hp[best]++;
			m_occ[best]--;
			m_slot[best][PTR_W'(m_hp[best] + m_occ[best])] = svc;
			m_occ[best]++;
			m_head[best] = m_slot[best][m_hp[best]];
		end
		fin = m_fin[best] + svc;
		if (fin > 65535) fin = 65535;
		r.server = SRV_W'(best);
		r.begin_at = m_fin[best];
		r.end_at = TIME_W'(fin);
		r.in_hours = (m_fin[best] < m_close);
		m_fin[best] = TIME_W'(fin);
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				checked++;
				if (!served) unserved++;
				if (finish_time == 16'hFFFF) saturated++;
				if (pending.size() == 0) begin
					report("result arrived with no job outstanding");
				end else begin
					want = pending.pop_front();
					if (server_index !== want.server)
						report($sformatf("server_index %0d, expected %0d",
							server_index, want.server));
					if (start_time !== want.begin_at)
						report($sformatf("start_time %0d, expected %0d",
							start_time, want.begin_at));
					if (finish_time !== want.end_at)
						report($sformatf("finish_time %0d, expected %0d",
							finish_time, want.end_at));
					if (served !== want.in_hours)
						report($sformatf("served %0b, expected %0b", served, want.in_hours));
				end
			end
			if (start && !busy) begin
				got = dispatch_job(service_time);
				if (pin_valid) begin
					expect_result(pin_want);
					pin_valid = 1'b0;
				end else begin
					expect_result(got);
				end
			end
		end
	end

	task automatic send_job(input logic [SVC_W-1:0] svc);
		@(negedge clk);
		start <= 1'b1;
		service_time <= svc;
		do @(posedge clk); while (busy);
		jobs++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic program_reg(input logic [1:0] sel, input logic [31:0] data);
		logic [31:0] kept;
		case (sel)
			REG_WINDOW_COUNT: kept = data & 32'h3F;
			REG_QUEUE_DEPTH:  kept = data & 32'h1F;
			default:          kept = data & 32'hFFFF;
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (sel)
			REG_WINDOW_COUNT: m_windows = WC_W'(kept);
			REG_QUEUE_DEPTH:  m_depth = QD_W'(kept);
			default:          m_close = TIME_W'(kept);
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== kept)
			report($sformatf("register %0d reads %0h, expected %0h", sel, prdata, kept));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		settings++;
	endtask

	function automatic plan_row_t reg_row(input logic [1:0] sel, input logic [31:0] value);
		plan_row_t r;
		r = '{default: '0};
		r.is_reg = 1'b1;
		r.reg_sel = sel;
		r.value = value;
		return r;
	endfunction

	function automatic plan_row_t job_row(input logic [SVC_W-1:0] svc, input bit pinned,
		input int server, input int begin_at, input int end_at, input bit in_hours);
		plan_row_t r;
		r = '{default: '0};
		r.svc = svc;
		r.pinned = pinned;
		r.want = '{SRV_W'(server), TIME_W'(begin_at), TIME_W'(end_at), in_hours};
		return r;
	endfunction

	function automatic logic [SVC_W-1:0] pick_service(input bit long_jobs);
		if (long_jobs) return SVC_W'($urandom_range(800, 1023));
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return SVC_W'($urandom_range(0, 15));
			default: return SVC_W'($urandom_range(0, 1023));
		endcase
	endfunction

	initial begin
		#20_000_000;
		$display("FAIL bounded_multi_queue_dispatcher");
		$finish;
	end

	initial begin
		int        burst, gap, wc, qd, ct;
		bit        long_jobs;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		service_time = '0;
		m_windows = 1;
		m_depth = 1;
		m_close = CLOSE_RESET;
		for (int s = 0; s < MAX_SERVERS; s++) begin
			m_head[s] = '0;
			m_occ[s] = '0;
			m_hp[s] = '0;
			m_fin[s] = '0;
		end

		// After reset one server holds one job, so each job behind the first
		// replaces the head and starts when the previous one finished.
		add_step(job_row(10'd0, 1, 0, 0, 0, 1));
		add_step(job_row(10'd1023, 1, 0, 0, 1023, 1));
		add_step(job_row(10'd1, 1, 0, 1023, 1024, 0));
		add_step(reg_row(REG_CLOSE_TIME, 32'hFFFF));
		add_step(reg_row(REG_WINDOW_COUNT, 32'd0));
		add_step(reg_row(REG_QUEUE_DEPTH, 32'd0));
		add_step(job_row(10'd512, 1, 0, 1024, 1536, 1));
		add_step(reg_row(REG_WINDOW_COUNT, 32'd63));
		add_step(reg_row(REG_QUEUE_DEPTH, 32'd31));
		add_step(job_row(10'd1023, 1, 1, 0, 1023, 1));
		add_step(job_row(10'd0, 1, 2, 0, 0, 1));
		add_step(job_row(10'd1, 1, 3, 0, 1, 1));
		add_step(reg_row(REG_WINDOW_COUNT, 32'd2));
		add_step(job_row(10'd7, 0, 0, 0, 0, 0));
		add_step(job_row(10'd9, 0, 0, 0, 0, 0));
		add_step(job_row(10'd3, 0, 0, 0, 0, 0));
		add_step(job_row(10'd5, 0, 0, 0, 0, 0));
		// The queues now hold more jobs than the new depth allows.
		add_step(reg_row(REG_QUEUE_DEPTH, 32'd2));
		add_step(job_row(10'd100, 0, 0, 0, 0, 0));
		add_step(job_row(10'd200, 0, 0, 0, 0, 0));
		add_step(job_row(10'd300, 0, 0, 0, 0, 0));
		add_step(reg_row(REG_CLOSE_TIME, 32'd0));
		add_step(job_row(10'd1023, 0, 0, 0, 0, 0));
		add_step(reg_row(REG_CLOSE_TIME, 32'd540));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[k]) begin
			if (plan[k].is_reg) begin
				wait_idle();
				program_reg(plan[k].reg_sel, plan[k].value);
			end else begin
				@(negedge clk);
				pin_valid = plan[k].pinned;
				pin_want = plan[k].want;
				send_job(plan[k].svc);
			end
		end

		// The first phase runs long jobs on one server to drive finish
		// times into saturation.
		for (int ph = 0; ph < 10; ph++) begin
			long_jobs = (ph == 0);
			case ($urandom_range(0, 5))
				0:       wc = 0;
				1:       wc = MAX_SERVERS;
				2:       wc = $urandom_range(33, 63);
				default: wc = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 5))
				0:       qd = 0;
				1:       qd = MAX_QUEUE;
				2:       qd = $urandom_range(17, 31);
				default: qd = $urandom_range(1, 4);
			endcase
			case ($urandom_range(0, 4))
				0:       ct = 0;
				1:       ct = 65535;
				default: ct = $urandom_range(0, 20000);
			endcase
			if (long_jobs) begin
				wc = 1;
				qd = 1;
			end
			wait_idle();
			program_reg(REG_WINDOW_COUNT, ($urandom & 32'hFFFF_FFC0) | wc);
			program_reg(REG_QUEUE_DEPTH, ($urandom & 32'hFFFF_FFE0) | qd);
			program_reg(REG_CLOSE_TIME, ($urandom & 32'hFFFF_0000) | ct);
			burst = $urandom_range(1, 24);
			for (int j = 0; j < 140; j++) begin
				if (burst == 0) begin
					if ($urandom_range(0, 39) == 0) begin
						wait_idle();
					end else begin
						gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 110)
							: $urandom_range(1, 8);
						@(negedge clk);
						start <= 1'b0;
						repeat (gap - 1) @(negedge clk);
					end
					burst = $urandom_range(1, 24);
				end
				send_job(pick_service(long_jobs));
				burst--;
			end
		end

		wait_idle();
		repeat (110) @(posedge clk);
		$display("Dispatched %0d jobs across %0d register writes with read-back.",
			jobs, settings);
		$display("Checked %0d results: %0d past closing time, %0d at the time ceiling.",
			checked, unserved, saturated);
		if (errors == 0) begin
			$display("PASS bounded_multi_queue_dispatcher");
		end else begin
			$display("FAIL bounded_multi_queue_dispatcher");
		end
		$finish;
	end

endmodule
